// ===== src/dwc_pkg.sv =====
`default_nettype none

package dwc_pkg;

    localparam int DWC_NUM_BUCKETS = 128;
    localparam int DWC_TOTAL_WIDTH = 32;

    localparam int WIN_W      = 21;
    localparam int RATIO_W    = 17;
    localparam int RATIO_FRAC = 16;
    localparam int FUNC_W     = 2;
    localparam int CFG_ADDR_W = 2;

    localparam int WIN_MAX   = 1048576;
    localparam int RATIO_ONE = 65536;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    // unused code, reports the current state
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELETE_TRIGGER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATIO          = 2'd2;

    typedef struct packed {
        logic             need_compaction;
        logic [WIN_W-1:0] window_deletions;
        logic             finished;
    } dwc_result_t;

endpackage

`default_nettype wire

// ===== src/deletion_window_compaction_flag.sv =====
// add, clear and unused-code words push their result into the output buffer when accepted
// throughput: one word per cycle if s_tready is high, by the prefetch read of the next bucket
// a finish word passes FIN_MUL (ratio multiply) and FIN_CMP (compare); s_tready is low in both
// reset: asynchronous, clears control state and the configuration registers to zero
// the bucket memory is not swept; entries not rewritten since the last clear are taken as zero
`default_nettype none

module deletion_window_compaction_flag #(
    parameter int NUM_BUCKETS = dwc_pkg::DWC_NUM_BUCKETS,
    parameter int TOTAL_WIDTH = dwc_pkg::DWC_TOTAL_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dwc_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] is_delete
    input  wire logic [dwc_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] func
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [dwc_pkg::M_TDATA_W-1:0]  m_tdata,   // [20:0] window_deletions
    output logic      [dwc_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] need_compaction, [1] finished
    input  wire logic                           cfg_we,
    input  wire logic [dwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [dwc_pkg::WIN_W-1:0]      cfg_data
);
    import dwc_pkg::*;

    localparam int CUR_W   = $clog2(NUM_BUCKETS);
    localparam int BSZ_MAX = (WIN_MAX + NUM_BUCKETS - 1) / NUM_BUCKETS;
    localparam int CNT_W   = $clog2(BSZ_MAX + 1);
    localparam int DIV_SH  = WIN_W + CUR_W;
    localparam longint DIV_M = ((longint'(1) << DIV_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS;
    localparam int DIV_M_W = WIN_W + 2;
    localparam int PROD_W  = WIN_W + DIV_M_W;

    localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(NUM_BUCKETS - 1);

    localparam logic [1:0] FIN_IDLE = 2'd0;
    localparam logic [1:0] FIN_MUL  = 2'd1;
    localparam logic [1:0] FIN_CMP  = 2'd2;

    // configuration
    logic [CNT_W-1:0]   bsize_reg;
    logic [WIN_W-1:0]   trigger_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [WIN_W-1:0]   win_clamped;
    logic [WIN_W-1:0]   win_plus;
    logic [PROD_W-1:0]  div_prod;
    logic [CNT_W-1:0]   bsize_cfg;

    // table state
    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic                   wrapped_reg, wrapped_next;
    logic [CNT_W-1:0]       keys_reg, keys_next;
    logic [CNT_W-1:0]       cur_cnt_reg, cur_cnt_next;
    logic [WIN_W-1:0]       wt_reg, wt_next;
    logic [TOTAL_WIDTH-1:0] et_reg, et_next;
    logic [TOTAL_WIDTH-1:0] dt_reg, dt_next;
    logic                   flag_reg, flag_next;
    logic                   done_reg, done_next;
    logic [1:0]             fin_phase_reg, fin_phase_next;

    logic             s_acc;
    logic             del;
    logic             ren;
    logic             add_active;
    logic             cursor_last;
    logic [CUR_W-1:0] cursor_inc;
    logic             adv;
    logic [CNT_W-1:0] rd_data;
    logic [CNT_W-1:0] old_cnt;
    logic [CUR_W-1:0] rd_addr;
    logic             mem_we;
    logic [WIN_W-1:0] wt_base;
    logic [WIN_W-1:0] wt_inc;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] keys_base;
    logic             ratio_hit;
    logic             buf_full;
    logic             res_push;
    dwc_result_t      res_data;
    dwc_result_t      out_res;

    // bucket size = ceil(min(win, WIN_MAX)/NUM_BUCKETS), reciprocal multiply, exact below 2^21
    assign win_clamped = (cfg_data > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : cfg_data;
    assign win_plus    = win_clamped + WIN_W'(NUM_BUCKETS - 1);
    assign div_prod    = PROD_W'(win_plus) * PROD_W'(DIV_M);
    assign bsize_cfg   = div_prod[DIV_SH +: CNT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg   <= '0;
            trigger_reg <= '0;
            ratio_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_WINDOW_SIZE:    bsize_reg   <= bsize_cfg;
                CFG_DELETE_TRIGGER: trigger_reg <= cfg_data;
                CFG_RATIO:          ratio_reg   <= cfg_data[RATIO_W-1:0];
                default:            ;
            endcase
        end
    end

    assign s_tready = !buf_full && (fin_phase_reg == FIN_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign del      = s_tdata[0];

    assign ren         = (ratio_reg != '0) && (ratio_reg <= RATIO_W'(RATIO_ONE));
    assign add_active  = !done_reg && !flag_reg && ((bsize_reg != '0) || ren);
    assign cursor_last = cursor_reg == CUR_LAST;
    assign cursor_inc  = cursor_last ? '0 : cursor_reg + 1'b1;
    assign adv         = keys_reg >= bsize_reg;
    // next bucket holds live data only once it has been left since the last clear
    assign old_cnt     = (wrapped_reg || cursor_last) ? rd_data : '0;
    assign wt_inc      = wt_base + 1'b1;

    always_comb
    begin
        cursor_next    = cursor_reg;
        wrapped_next   = wrapped_reg;
        keys_next      = keys_reg;
        cur_cnt_next   = cur_cnt_reg;
        wt_next        = wt_reg;
        et_next        = et_reg;
        dt_next        = dt_reg;
        flag_next      = flag_reg;
        done_next      = done_reg;
        fin_phase_next = fin_phase_reg;
        mem_we         = 1'b0;
        res_push       = 1'b0;
        wt_base        = wt_reg;
        cnt_base       = cur_cnt_reg;
        keys_base      = keys_reg;
        if (adv)
        begin
            wt_base   = (wt_reg >= WIN_W'(old_cnt)) ? wt_reg - WIN_W'(old_cnt) : '0;
            cnt_base  = '0;
            keys_base = '0;
        end

        unique case (fin_phase_reg)
            FIN_IDLE:
            begin
                if (s_acc)
                begin
                    res_push = s_tuser != FUNC_FINISH;
                    unique case (s_tuser)
                        FUNC_ADD:
                        begin
                            if (add_active)
                            begin
                                if (ren)
                                begin
                                    if (et_reg != '1)
                                    begin
                                        et_next = et_reg + 1'b1;
                                    end
                                    if (del && (dt_reg != '1))
                                    begin
                                        dt_next = dt_reg + 1'b1;
                                    end
                                end
                                if (bsize_reg != '0)
                                begin
                                    if (adv)
                                    begin
                                        // retire the filled bucket, drop the oldest one
                                        mem_we       = 1'b1;
                                        cursor_next  = cursor_inc;
                                        wrapped_next = wrapped_reg | cursor_last;
                                    end
                                    keys_next = keys_base + 1'b1;
                                    if (del)
                                    begin
                                        wt_next      = wt_inc;
                                        cur_cnt_next = cnt_base + 1'b1;
                                        if (wt_inc >= trigger_reg)
                                        begin
                                            flag_next = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        wt_next      = wt_base;
                                        cur_cnt_next = cnt_base;
                                    end
                                end
                            end
                        end
                        FUNC_FINISH:
                        begin
                            fin_phase_next = FIN_MUL;
                        end
                        FUNC_CLEAR:
                        begin
                            cursor_next  = '0;
                            wrapped_next = 1'b0;
                            keys_next    = '0;
                            cur_cnt_next = '0;
                            wt_next      = '0;
                            et_next      = '0;
                            dt_next      = '0;
                            flag_next    = 1'b0;
                            done_next    = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            FIN_MUL:
            begin
                fin_phase_next = FIN_CMP;
            end
            FIN_CMP:
            begin
                if (!flag_reg && ren && (et_reg != '0))
                begin
                    flag_next = ratio_hit;
                end
                done_next      = 1'b1;
                res_push       = 1'b1;
                fin_phase_next = FIN_IDLE;
            end
            default:
            begin
                fin_phase_next = FIN_IDLE;
            end
        endcase

        res_data.need_compaction  = flag_next;
        res_data.window_deletions = wt_next;
        res_data.finished         = done_next;
    end

    // prefetch the bucket after the (next) cursor: it is the one dropped on advance
    assign rd_addr = (cursor_next == CUR_LAST) ? '0 : cursor_next + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            wrapped_reg   <= 1'b0;
            keys_reg      <= '0;
            cur_cnt_reg   <= '0;
            wt_reg        <= '0;
            et_reg        <= '0;
            dt_reg        <= '0;
            flag_reg      <= 1'b0;
            done_reg      <= 1'b0;
            fin_phase_reg <= FIN_IDLE;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            wrapped_reg   <= wrapped_next;
            keys_reg      <= keys_next;
            cur_cnt_reg   <= cur_cnt_next;
            wt_reg        <= wt_next;
            et_reg        <= et_next;
            dt_reg        <= dt_next;
            flag_reg      <= flag_next;
            done_reg      <= done_next;
            fin_phase_reg <= fin_phase_next;
        end
    end

    dwc_bucket_mem #(
        .DEPTH  (NUM_BUCKETS),
        .WIDTH  (CNT_W),
        .ADDR_W (CUR_W)
    ) u_bucket_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cursor_reg),
        .wdata (cur_cnt_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    dwc_ratio_chk #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_ratio_chk (
        .clk          (clk),
        .ratio        (ratio_reg),
        .entry_total  (et_reg),
        .delete_total (dt_reg),
        .hit          (ratio_hit)
    );

    dwc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (buf_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_res)
    );

    assign m_tdata = M_TDATA_W'(out_res.window_deletions);
    assign m_tuser = {out_res.finished, out_res.need_compaction};

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (s_tuser == FUNC_FINISH)) |-> ##2 (res_push && res_data.finished))
        else $error("finish word did not produce its result after the ratio check");

    a_flag_freezes_window: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_reg && !(s_acc && (s_tuser == FUNC_CLEAR))) |=> $stable(wt_reg))
        else $error("window total moved while the compaction flag was set");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !buf_full)
        else $error("result pushed into a full output buffer");

endmodule

`default_nettype wire

// ===== src/dwc_bucket_mem.sv =====
`default_nettype none

module dwc_bucket_mem #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 14,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first forwarding when both ports hit the same bucket
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/dwc_ratio_chk.sv =====
`default_nettype none

module dwc_ratio_chk #(
    parameter int TOTAL_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic [dwc_pkg::RATIO_W-1:0] ratio,
    input  wire logic [TOTAL_WIDTH-1:0]      entry_total,
    input  wire logic [TOTAL_WIDTH-1:0]      delete_total,
    output logic                             hit
);
    import dwc_pkg::*;

    localparam int CMP_W = TOTAL_WIDTH + RATIO_W;

    logic [CMP_W-1:0] prod_reg;
    logic [CMP_W-1:0] del_scaled;

    // product is registered: it is ready in the cycle after the totals settle
    always_ff @(posedge clk)
    begin
        prod_reg <= CMP_W'(ratio) * CMP_W'(entry_total);
    end

    assign del_scaled = CMP_W'({delete_total, RATIO_FRAC'(0)});
    assign hit        = del_scaled >= prod_reg;

endmodule

`default_nettype wire

// ===== src/dwc_out_buf.sv =====
`default_nettype none

module dwc_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire dwc_pkg::dwc_result_t push_data,
    output logic                      full,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dwc_pkg::dwc_result_t      m_data
);
    import dwc_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    dwc_result_t out_data_reg, out_data_next;
    dwc_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && m_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full    = skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
